// ----- design/nrwt_pkg.sv -----
// nrwt_pkg: opcodes, status codes and the name normalization function
// shared by the route tracker modules. No dependencies.
package nrwt_pkg;

  localparam int unsigned NameW = 64;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_NAME  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;
  localparam logic [1:0] OP_COORD = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_SYNC = 2'd2;

  // Keep only the first nchars bytes, and nothing from the first zero byte on.
  function automatic logic [NameW-1:0] canon_name(input logic [NameW-1:0] raw,
                                                  input int unsigned nchars);
    logic [NameW-1:0] out;
    logic             stop;
    out  = '0;
    stop = 1'b0;
    for (int unsigned k = 0; k < 8; k++) begin
      if (k >= nchars || raw[8*k +: 8] == 8'h00) begin
        stop = 1'b1;
      end
      if (!stop) begin
        out[8*k +: 8] = raw[8*k +: 8];
      end
    end
    return out;
  endfunction

endpackage

// ----- design/nmea_route_waypoint_tracker.sv -----
// nmea_route_waypoint_tracker: top level, command sequencer and state registers.
// Depends on nrwt_pkg, nrwt_name_mem and nrwt_coord_mem.
//
// Builds a navigation route from start, waypoint name, end and coordinate
// items. An item is taken at a clock edge where start is high and busy is low;
// its result appears for exactly one cycle with done_o high, and must be taken
// then, since there is no way to hold it off. Start route items, end items
// that do not search and items refused because the table is full show their
// result in the next cycle. Name and coordinate items pass through S_CHECK:
// the stored name is read synchronously first, then compared and written back.
// End route of the complete type with two or more waypoints walks the stored
// names one per cycle through the single read port until the first match or
// the last entry. busy is low again in the cycle that shows the result, so a
// new item can be taken while the previous result is on the ports.
module nmea_route_waypoint_tracker #(
  parameter int unsigned MAX_WAYPOINTS = 32,
  parameter int unsigned NAME_CHARS    = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 opcode_i,
  input  logic [15:0]                route_number_i,
  input  logic [63:0]                wp_name_i,
  input  logic                       route_kind_i,
  input  logic signed [30:0]         lat_fixed_i,
  input  logic signed [31:0]         lon_fixed_i,
  output logic                       done_o,
  output logic [1:0]                 status_o,
  output logic                       route_ok_o,
  output logic                       same_as_before_o,
  output logic [5:0]                 route_length_o,
  output logic [4:0]                 origin_slot_o,
  output logic [15:0]                current_route_o
);

  localparam int unsigned IdxW = $clog2(MAX_WAYPOINTS);      // table index
  localparam int unsigned CurW = $clog2(MAX_WAYPOINTS + 1);  // cursor, holds the depth

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,   // stored name at cursor is on the read port
    S_SEARCH   // origin lookup, one stored name per cycle
  } state_e;

  state_e                      state_q;
  logic                        done_q;
  logic [1:0]                  status_q;
  logic [1:0]                  op_q;
  logic [nrwt_pkg::NameW-1:0]  name_q;
  logic signed [30:0]          lat_q;
  logic signed [31:0]          lon_q;
  logic [CurW-1:0]             cursor_q;
  logic [CurW-1:0]             length_q;
  logic                        equal_q;
  logic                        valid_q;
  logic [IdxW-1:0]             origin_q;
  logic [15:0]                 route_id_q;
  logic [IdxW-1:0]             idx_q;

  logic [nrwt_pkg::NameW-1:0]  name_in;
  logic [IdxW-1:0]             cur_idx;
  logic [IdxW-1:0]             rd_addr;
  logic [nrwt_pkg::NameW-1:0]  rd_data;
  logic                        name_hit;
  logic                        name_wr;
  logic                        coord_wr;
  logic                        search_last;

  assign name_in     = nrwt_pkg::canon_name(wp_name_i, NAME_CHARS);
  assign cur_idx     = cursor_q[IdxW-1:0];
  assign name_hit    = (rd_data == name_q);
  assign search_last = ((CurW'(idx_q) + CurW'(1)) == cursor_q);

  // Read address: cursor entry for name/coordinate items, entry 0 to open
  // an origin search, then the next entry while the search goes on.
  always_comb begin
    case (state_q)
      S_IDLE:   rd_addr = (opcode_i == nrwt_pkg::OP_END) ? '0 : cur_idx;
      S_SEARCH: rd_addr = idx_q + IdxW'(1);
      default:  rd_addr = cur_idx;
    endcase
  end

  // Write-back happens in the compare cycle; the next read is taken only after
  // the block is back in S_IDLE, so no forwarding is needed.
  assign name_wr  = (state_q == S_CHECK) && (op_q == nrwt_pkg::OP_NAME) &&
                    (!equal_q || !name_hit);
  assign coord_wr = (state_q == S_CHECK) && (op_q == nrwt_pkg::OP_COORD) && name_hit;

  nrwt_name_mem #(
    .Depth (MAX_WAYPOINTS)
  ) u_name_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (name_wr),
    .wr_addr_i (cur_idx),
    .wr_data_i (name_q),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  nrwt_coord_mem #(
    .Depth (MAX_WAYPOINTS)
  ) u_coord_mem (
    .clk_i     (clk_i),
    .wr_en_i   (coord_wr),
    .wr_addr_i (cur_idx),
    .lat_i     (lat_q),
    .lon_i     (lon_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      done_q     <= 1'b0;
      status_q   <= nrwt_pkg::ST_OK;
      op_q       <= nrwt_pkg::OP_START;
      cursor_q   <= '0;
      length_q   <= '0;
      equal_q    <= 1'b1;
      valid_q    <= 1'b0;
      origin_q   <= '0;
      route_id_q <= '0;
      idx_q      <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            op_q  <= opcode_i;
            idx_q <= '0;
            case (opcode_i)
              nrwt_pkg::OP_START: begin
                route_id_q <= route_number_i;
                equal_q    <= 1'b1;
                valid_q    <= 1'b0;
                length_q   <= '0;
                cursor_q   <= '0;
                status_q   <= nrwt_pkg::ST_OK;
                done_q     <= 1'b1;
              end
              nrwt_pkg::OP_NAME, nrwt_pkg::OP_COORD: begin
                if (cursor_q >= CurW'(MAX_WAYPOINTS)) begin
                  status_q <= nrwt_pkg::ST_FULL;
                  done_q   <= 1'b1;
                end else begin
                  state_q <= S_CHECK;
                end
              end
              nrwt_pkg::OP_END: begin
                // search only a complete route with two or more entries
                if (route_kind_i && (cursor_q > CurW'(1))) begin
                  state_q <= S_SEARCH;
                end else begin
                  origin_q <= '0;
                  valid_q  <= valid_q | equal_q;
                  length_q <= cursor_q;
                  cursor_q <= '0;
                  status_q <= nrwt_pkg::ST_OK;
                  done_q   <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        S_CHECK: begin
          state_q  <= S_IDLE;
          done_q   <= 1'b1;
          status_q <= nrwt_pkg::ST_OK;
          if (op_q == nrwt_pkg::OP_NAME) begin
            if (!equal_q || !name_hit) begin
              equal_q <= 1'b0;
            end
            cursor_q <= cursor_q + CurW'(1);
          end else if (name_hit) begin
            cursor_q <= cursor_q + CurW'(1);
          end else begin
            valid_q  <= 1'b0;
            status_q <= nrwt_pkg::ST_SYNC;
          end
        end
        S_SEARCH: begin
          if (name_hit || search_last) begin
            // first match wins; no match leaves the origin at entry 0
            origin_q <= name_hit ? idx_q : '0;
            valid_q  <= valid_q | equal_q;
            length_q <= cursor_q;
            cursor_q <= '0;
            status_q <= nrwt_pkg::ST_OK;
            done_q   <= 1'b1;
            state_q  <= S_IDLE;
          end else begin
            idx_q <= idx_q + IdxW'(1);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload of the item being worked on
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      name_q <= name_in;
      lat_q  <= lat_fixed_i;
      lon_q  <= lon_fixed_i;
    end
  end

  assign busy             = (state_q != S_IDLE);
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign route_ok_o       = valid_q;
  assign same_as_before_o = equal_q;
  assign route_length_o   = 6'(length_q);
  assign origin_slot_o    = 5'(origin_q);
  assign current_route_o  = route_id_q;

endmodule

// ----- design/nrwt_name_mem.sv -----
// nrwt_name_mem: waypoint name store, one write and one registered read port.
// Per-entry valid bits make never-written entries read as zero. Uses nrwt_pkg.
module nrwt_name_mem #(
  parameter int unsigned Depth = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            wr_en_i,
  input  logic [$clog2(Depth)-1:0]        wr_addr_i,
  input  logic [nrwt_pkg::NameW-1:0]      wr_data_i,
  input  logic [$clog2(Depth)-1:0]        rd_addr_i,
  output logic [nrwt_pkg::NameW-1:0]      rd_data_o
);

  logic [nrwt_pkg::NameW-1:0] mem [Depth];
  logic [Depth-1:0]           vld_q;
  logic [nrwt_pkg::NameW-1:0] rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= vld_q[rd_addr_i] ? mem[rd_addr_i] : '0;
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- design/nrwt_coord_mem.sv -----
// nrwt_coord_mem: latitude and longitude store, one write port.
// Coordinates are kept for the route but never read back by the tracker.
module nrwt_coord_mem #(
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic signed [30:0]       lat_i,
  input  logic signed [31:0]       lon_i
);

  logic signed [30:0] lat_mem [Depth];
  logic signed [31:0] lon_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      lat_mem[wr_addr_i] <= lat_i;
      lon_mem[wr_addr_i] <= lon_i;
    end
  end

endmodule

// ----- design/nrwt_checker.sv -----
// nrwt_checker: port-level assertions for the route tracker, bound to the top.
// Depends on nrwt_pkg and nmea_route_waypoint_tracker.
module nrwt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [1:0] opcode_i,
  input logic       done_o,
  input logic [1:0] status_o,
  input logic       route_ok_o,
  input logic       same_as_before_o,
  input logic [5:0] route_length_o
);

  // a result only shows once the block is free again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == nrwt_pkg::ST_OK || status_o == nrwt_pkg::ST_FULL ||
                status_o == nrwt_pkg::ST_SYNC))
    else $error("undefined status code");

  a_start_route: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i == nrwt_pkg::OP_START) |=>
      (done_o && status_o == nrwt_pkg::ST_OK && !route_ok_o && same_as_before_o &&
       route_length_o == 6'd0))
    else $error("start route result wrong");

  a_name_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i == nrwt_pkg::OP_NAME) |=>
      (busy || (done_o && status_o == nrwt_pkg::ST_FULL)))
    else $error("name item neither read nor refused");

endmodule

bind nmea_route_waypoint_tracker nrwt_checker u_nrwt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .opcode_i         (opcode_i),
  .done_o           (done_o),
  .status_o         (status_o),
  .route_ok_o       (route_ok_o),
  .same_as_before_o (same_as_before_o),
  .route_length_o   (route_length_o)
);

// ----- tb/testbench.sv -----
// testbench: self-checking bench for nmea_route_waypoint_tracker.
// Depends on nrwt_pkg (opcodes, status codes) and the tracker RTL only.
// Drives directed routes, then random route sequences, against a cycle-free shadow predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WAYPOINTS  = 32;
  localparam int unsigned NAME_BYTES = 8;
  localparam int          POOL       = 24;      // distinct waypoint names used by random routes
  localparam int          RANDOM_ITEMS = 1600;
  localparam int          DRAIN      = 40;      // extra wait after the last result due
  localparam int          LIMIT      = 400000;  // hard stop if the run hangs

  // one result item as the block presents it
  typedef struct packed {
    logic [1:0]  status;
    logic        ok;
    logic        same;
    logic [5:0]  length;
    logic [4:0]  origin;
    logic [15:0] route;
  } route_result_t;

  // Shadow copy of the tracker state. Every accepted item is applied here in
  // order, and the outputs after that item are queued as the next result due.
  class route_shadow;
    logic [63:0]   name_tab [WAYPOINTS];
    int unsigned   cursor;
    logic [5:0]    length;
    logic          equal_f;
    logic          valid_f;
    logic [4:0]    origin;
    logic [15:0]   route_id;
    route_result_t pending [$];
    int unsigned   mismatches;

    function new();
      foreach (name_tab[i]) name_tab[i] = '0;
      cursor     = 0;
      length     = '0;
      equal_f    = 1'b1;
      valid_f    = 1'b0;
      origin     = '0;
      route_id   = '0;
      mismatches = 0;
    endfunction

    // bytes count up to the first zero byte, and no further than NAME_BYTES
    function logic [63:0] trim_name(logic [63:0] raw);
      logic [63:0] kept;
      kept = '0;
      for (int k = 0; k < NAME_BYTES && k < 8; k++) begin
        if (raw[8*k +: 8] == 8'h00) break;
        kept[8*k +: 8] = raw[8*k +: 8];
      end
      return kept;
    endfunction

    function void accept_item(logic [1:0] op, logic [15:0] num, logic [63:0] raw, logic kind);
      logic [63:0]   nm;
      logic [1:0]    st;
      bit            found;
      route_result_t res;
      nm    = trim_name(raw);
      st    = nrwt_pkg::ST_OK;
      found = 1'b0;
      case (op)
        nrwt_pkg::OP_START: begin
          // origin is left alone on purpose
          route_id = num;
          equal_f  = 1'b1;
          valid_f  = 1'b0;
          length   = '0;
          cursor   = 0;
        end
        nrwt_pkg::OP_NAME: begin
          if (cursor >= WAYPOINTS) begin
            st = nrwt_pkg::ST_FULL;
          end else begin
            if (!equal_f || name_tab[cursor] != nm) begin
              name_tab[cursor] = nm;
              equal_f          = 1'b0;
            end
            cursor++;
          end
        end
        nrwt_pkg::OP_END: begin
          origin = '0;
          // a one-waypoint complete route never searches
          if (kind && cursor != 1) begin
            for (int unsigned i = 0; i < cursor && i < WAYPOINTS; i++) begin
              if (!found && name_tab[i] == nm) begin
                origin = 5'(i);
                found  = 1'b1;
              end
            end
          end
          if (equal_f) valid_f = 1'b1;
          length = 6'(cursor);
          cursor = 0;
        end
        default: begin
          // coordinates: lat/lon land in tables that never reach the outputs
          if (cursor >= WAYPOINTS) begin
            st = nrwt_pkg::ST_FULL;
          end else if (name_tab[cursor] == nm) begin
            cursor++;
          end else begin
            valid_f = 1'b0;
            st      = nrwt_pkg::ST_SYNC;
          end
        end
      endcase
      res = '{st, valid_f, equal_f, length, origin, route_id};
      pending.push_back(res);
    endfunction

    function void flag(string field, logic [15:0] want, logic [15:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
    endfunction

    function void check_result(route_result_t got);
      route_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result %h with no item outstanding", $time, got);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status)
        flag("status", 16'(want.status), 16'(got.status));
      if (got.ok     !== want.ok)
        flag("route_ok", 16'(want.ok), 16'(got.ok));
      if (got.same   !== want.same)
        flag("same_as_before", 16'(want.same), 16'(got.same));
      if (got.length !== want.length)
        flag("route_length", 16'(want.length), 16'(got.length));
      if (got.origin !== want.origin)
        flag("origin_slot", 16'(want.origin), 16'(got.origin));
      if (got.route  !== want.route)  flag("current_route", want.route, got.route);
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [1:0]         opcode;
  logic [15:0]        route_number;
  logic [63:0]        wp_name;
  logic               route_kind;
  logic signed [30:0] lat_fixed;
  logic signed [31:0] lon_fixed;
  logic               done_o;
  logic [1:0]         status_o;
  logic               route_ok_o;
  logic               same_as_before_o;
  logic [5:0]         route_length_o;
  logic [4:0]         origin_slot_o;
  logic [15:0]        current_route_o;

  route_shadow shadow;
  int          items_sent;
  int          burst_left;
  logic [63:0] pool_name [POOL];
  int          pool_len  [POOL];
  int          prev_route [$];

  nmea_route_waypoint_tracker #(
    .MAX_WAYPOINTS(WAYPOINTS),
    .NAME_CHARS   (NAME_BYTES)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .opcode_i        (opcode),
    .route_number_i  (route_number),
    .wp_name_i       (wp_name),
    .route_kind_i    (route_kind),
    .lat_fixed_i     (lat_fixed),
    .lon_fixed_i     (lon_fixed),
    .done_o          (done_o),
    .status_o        (status_o),
    .route_ok_o      (route_ok_o),
    .same_as_before_o(same_as_before_o),
    .route_length_o  (route_length_o),
    .origin_slot_o   (origin_slot_o),
    .current_route_o (current_route_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Monitor: everything is sampled at the rising edge, before the block's own
  // updates land. The result due is checked before a newly taken item is queued.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o)
        shadow.check_result({status_o, route_ok_o, same_as_before_o, route_length_o,
                             origin_slot_o, current_route_o});
      if (start && !busy)
        shadow.accept_item(opcode, route_number, wp_name, route_kind);
    end
  end

  // hard stop if the block hangs or results go missing
  initial begin
    repeat (LIMIT) @(posedge clk_i);
    $display("nmea_route_waypoint_tracker: mismatch");
    $finish;
  end

  function automatic logic signed [30:0] rand_lat();
    return 31'(int'($urandom_range(0, 1800000000)) - 900000000);
  endfunction

  function automatic logic signed [31:0] rand_lon();
    return 32'(longint'($urandom_range(0, 32'd3600000000)) - 64'sd1800000000);
  endfunction

  // pool name with random junk behind its terminator half the time, for names
  // shorter than seven bytes; the junk must not change how the block sees the name
  function automatic logic [63:0] dirty(int idx);
    logic [63:0] raw;
    raw = pool_name[idx];
    if (pool_len[idx] < 7 && $urandom_range(0, 1))
      raw |= {$urandom, $urandom} << (8 * (pool_len[idx] + 1));
    return raw;
  endfunction

  // Drive one item at the falling edge and hold it until taken. The sender
  // works in bursts; between bursts start sits low for a random gap, and now
  // and then a long burst gives a stretch with no idling at all.
  task automatic send_item(input logic [1:0] op, input logic [15:0] num,
                           input logic [63:0] nm, input logic kind,
                           input logic signed [30:0] lat, input logic signed [31:0] lon);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk_i);
        start = 1'b0;
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk_i);
    start        = 1'b1;
    opcode       = op;
    route_number = num;
    wp_name      = nm;
    route_kind   = kind;
    lat_fixed    = lat;
    lon_fixed    = lon;
    do @(posedge clk_i); while (busy);
    items_sent++;
  endtask

  // name-carrying item with everything else random
  task automatic send_op(input logic [1:0] op, input logic [63:0] nm, input logic kind);
    send_item(op, 16'($urandom), nm, kind, rand_lat(), rand_lon());
  endtask

  task automatic send_noise();
    logic [63:0] nm;
    nm = $urandom_range(0, 1) ? dirty($urandom_range(0, POOL - 1)) : {$urandom, $urandom};
    send_op(2'($urandom_range(0, 3)), nm, 1'($urandom));
  endtask

  // A well-formed route: start, its names, end, then most times the coordinates in order.
  // Half the routes repeat the previous one so they can turn valid; a few
  // carry a wrong name or a stray item, and a few run past the table size.
  task automatic run_route();
    int          n;
    int          names [$];
    logic [63:0] org;
    send_op(nrwt_pkg::OP_START, {$urandom, $urandom}, 1'($urandom));
    if (prev_route.size() > 0 && $urandom_range(0, 1)) begin
      names = prev_route;
      if ($urandom_range(0, 3) == 0)
        names[$urandom_range(0, names.size() - 1)] = $urandom_range(0, POOL - 1);
    end else begin
      n = ($urandom_range(0, 11) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 8);
      repeat (n) names.push_back($urandom_range(0, POOL - 1));
    end
    foreach (names[k]) send_op(nrwt_pkg::OP_NAME, dirty(names[k]), 1'($urandom));
    if ($urandom_range(0, 5) == 0) send_noise();
    if (names.size() > 0 && $urandom_range(0, 3) != 0)
      org = dirty(names[$urandom_range(0, names.size() - 1)]);
    else
      org = {$urandom, $urandom};
    send_op(nrwt_pkg::OP_END, org, 1'($urandom));
    if ($urandom_range(0, 3) != 0) begin
      foreach (names[k]) begin
        if (k < WAYPOINTS)
          send_op(nrwt_pkg::OP_COORD,
                  ($urandom_range(0, 9) == 0) ? dirty($urandom_range(0, POOL - 1))
                                              : dirty(names[k]), 1'($urandom));
      end
    end
    prev_route = names;
  endtask

  initial begin
    logic [63:0] n_ff, n_ab, n_zg, n_zz;
    // names: all-ones, "AB" with junk behind its zero, empty with junk, "ZZ"
    n_ff = 64'hFFFF_FFFF_FFFF_FFFF;
    n_ab = 64'h5ADE_ADBE_EF00_4241;
    n_zg = 64'h1234_5678_9ABC_DE00;
    n_zz = 64'h0000_0000_0000_5A5A;

    shadow       = new();
    items_sent   = 0;
    burst_left   = 0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    opcode       = nrwt_pkg::OP_START;
    route_number = '0;
    wp_name      = '0;
    route_kind   = 1'b0;
    lat_fixed    = '0;
    lon_fixed    = '0;

    for (int i = 0; i < POOL; i++) begin
      pool_len[i]  = (i == 0) ? 0 : $urandom_range(1, 8);
      pool_name[i] = '0;
      for (int k = 0; k < pool_len[i]; k++) pool_name[i][8*k +: 8] = 8'($urandom_range(1, 255));
    end

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // --- directed part ---
    send_item(nrwt_pkg::OP_START, 16'hFFFF, n_ff, 1'b1, rand_lat(), rand_lon());
    send_op(nrwt_pkg::OP_NAME, 64'h0, 1'b0);          // equals the reset table entry
    send_op(nrwt_pkg::OP_NAME, n_ff, 1'b1);           // differs: stored, equal flag drops
    send_op(nrwt_pkg::OP_NAME, n_ab, 1'b0);
    // empty name with junk matches the untouched entry; extreme coordinates
    send_item(nrwt_pkg::OP_COORD, 16'h0, n_zg, 1'b0, 31'sd900000000, -32'sd1800000000);
    // name mismatch: coordinates out of sync
    send_item(nrwt_pkg::OP_COORD, 16'hFFFF, n_ff, 1'b1, -31'sd900000000, 32'sd1800000000);
    send_op(nrwt_pkg::OP_END, 64'h4241, 1'b1);        // origin found in the middle
    send_item(nrwt_pkg::OP_START, 16'h0000, n_zz, 1'b0, rand_lat(), rand_lon()); // origin kept
    send_op(nrwt_pkg::OP_NAME, n_zg, 1'b1);           // same route again
    send_op(nrwt_pkg::OP_NAME, n_ff, 1'b0);
    send_op(nrwt_pkg::OP_NAME, 64'h0000_0000_0000_4241, 1'b1);
    send_op(nrwt_pkg::OP_END, n_ff, 1'b1);            // repeated route turns valid
    send_op(nrwt_pkg::OP_COORD, 64'h0, 1'b0);
    send_op(nrwt_pkg::OP_COORD, n_ff, 1'b1);
    send_op(nrwt_pkg::OP_COORD, n_zg, 1'b0);          // wrong name clears valid
    send_op(nrwt_pkg::OP_END, n_ab, 1'b0);            // working type: origin forced to zero
    send_item(nrwt_pkg::OP_START, 16'h8001, n_ab, 1'b1, rand_lat(), rand_lon());
    send_op(nrwt_pkg::OP_NAME, n_ab, 1'b0);
    send_op(nrwt_pkg::OP_END, n_ab, 1'b1);            // single waypoint: no search
    send_item(nrwt_pkg::OP_START, 16'h7FFE, n_ab, 1'b0, rand_lat(), rand_lon());
    send_op(nrwt_pkg::OP_NAME, 64'h0, 1'b1);
    send_op(nrwt_pkg::OP_NAME, n_ab, 1'b0);
    send_op(nrwt_pkg::OP_NAME, n_ab, 1'b1);           // duplicate: lowest index must win
    send_op(nrwt_pkg::OP_END, n_ab, 1'b1);
    send_op(nrwt_pkg::OP_END, n_zz, 1'b1);            // empty route: nothing to search

    // --- random part: mostly routes, some loose noise items ---
    while (items_sent < 25 + RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 6)) send_noise();
      else run_route();
    end

    @(negedge clk_i);
    start = 1'b0;
    while (shadow.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    if (shadow.mismatches == 0 && shadow.pending.size() == 0)
      $display("nmea_route_waypoint_tracker: match");
    else
      $display("nmea_route_waypoint_tracker: mismatch");
    $finish;
  end

endmodule
